@@ src/sis_pkg.sv @@
// Shared types and constants for the SCSI interrupt stacker.
// Used by the register block, the update engine and the top level.
`default_nettype none

package sis_pkg;

   localparam int DataWidth = 8;

   localparam logic [DataWidth-1:0] DMA_FATAL_MASK   = 8'd125;
   localparam logic [DataWidth-1:0] SCSI0_FATAL_MASK = 8'd143;
   localparam logic [DataWidth-1:0] SCSI1_FATAL_MASK = 8'd20;
   localparam logic [DataWidth-1:0] DMA_CHECK_MASK   = 8'd127;
   localparam logic [DataWidth-1:0] DMA_DONE_BIT     = 8'd128;

   localparam int IST_DIP_POS  = 0;
   localparam int IST_SIP_POS  = 1;
   localparam int IST_INTF_POS = 2;

   localparam int CsrAddrWidth = 4;
   localparam int CsrDataWidth = 32;

   typedef enum logic [2:0] {
      OP_POST_DSTAT  = 3'd0,
      OP_POST_SIST0  = 3'd1,
      OP_POST_SIST1  = 3'd2,
      OP_POST_ISTAT  = 3'd3,
      OP_CLEAR_DSTAT = 3'd4,
      OP_CLEAR_SIST0 = 3'd5,
      OP_CLEAR_SIST1 = 3'd6,
      OP_CLEAR_ISTAT = 3'd7
   } opcode_type;

   typedef enum logic [1:0] {
      REG_DMA_INT_ENABLE   = 2'd0,
      REG_SCSI_INT_ENABLE0 = 2'd1,
      REG_SCSI_INT_ENABLE1 = 2'd2,
      REG_IRQ_DISABLE      = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [DataWidth-1:0] dma_int_enable;
      logic [DataWidth-1:0] scsi_int_enable0;
      logic [DataWidth-1:0] scsi_int_enable1;
      logic                 irq_disable;
   } cfg_type;

   typedef struct packed {
      logic                 irq_line;
      logic                 halt_request;
      logic [DataWidth-1:0] istat_value;
      logic [DataWidth-1:0] read_value;
      logic                 bad_opcode;
   } result_type;

endpackage

`default_nettype wire

@@ src/sis_csr.sv @@
// Configuration registers of the SCSI interrupt stacker on an APB-style port.
// Depends on sis_pkg for the register map and the configuration struct.
`default_nettype none

module sis_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [sis_pkg::CsrAddrWidth-1:0]     csr_paddr,
   input  wire logic [sis_pkg::CsrDataWidth-1:0]     csr_pwdata,
   output logic      [sis_pkg::CsrDataWidth-1:0]     csr_prdata,
   output logic                                      csr_pready,
   output sis_pkg::cfg_type                          cfg
);

   sis_pkg::cfg_type       cfg_ff;
   sis_pkg::cfg_type       cfg_in;
   sis_pkg::reg_index_type index;
   logic                   write_en;

   assign index      = sis_pkg::reg_index_type'(csr_paddr[3:2]);
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            sis_pkg::REG_DMA_INT_ENABLE:
               cfg_in.dma_int_enable = csr_pwdata[sis_pkg::DataWidth-1:0];
            sis_pkg::REG_SCSI_INT_ENABLE0:
               cfg_in.scsi_int_enable0 = csr_pwdata[sis_pkg::DataWidth-1:0];
            sis_pkg::REG_SCSI_INT_ENABLE1:
               cfg_in.scsi_int_enable1 = csr_pwdata[sis_pkg::DataWidth-1:0];
            sis_pkg::REG_IRQ_DISABLE:
               cfg_in.irq_disable = csr_pwdata[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (index)
         sis_pkg::REG_DMA_INT_ENABLE:
            csr_prdata[sis_pkg::DataWidth-1:0] = cfg_ff.dma_int_enable;
         sis_pkg::REG_SCSI_INT_ENABLE0:
            csr_prdata[sis_pkg::DataWidth-1:0] = cfg_ff.scsi_int_enable0;
         sis_pkg::REG_SCSI_INT_ENABLE1:
            csr_prdata[sis_pkg::DataWidth-1:0] = cfg_ff.scsi_int_enable1;
         sis_pkg::REG_IRQ_DISABLE:
            csr_prdata[0] = cfg_ff.irq_disable;
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

@@ src/sis_engine.sv @@
// Status registers, second-level stacks and the single-pass interrupt update.
// Depends on sis_pkg for opcodes, masks and the result struct.
`default_nettype none

module sis_engine (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              fire,
   input  wire logic [2:0]                        opcode,
   input  wire logic [sis_pkg::DataWidth-1:0]     bits,
   input  wire logic                              host_irq_mask,
   input  wire sis_pkg::cfg_type                  cfg,
   output sis_pkg::result_type                    result
);

   localparam int W = sis_pkg::DataWidth;

   logic [W-1:0] dstat_ff, dstat_in;
   logic [W-1:0] sist0_ff, sist0_in;
   logic [W-1:0] sist1_ff, sist1_in;
   logic [W-1:0] istat_ff, istat_in;
   logic [W-1:0] dstack_ff, dstack_in;
   logic [W-1:0] sstack0_ff, sstack0_in;
   logic [W-1:0] sstack1_ff, sstack1_in;

   always_comb begin
      logic [W-1:0] dstat_p, sist0_p, sist1_p, istat_p;
      logic [W-1:0] dstack_p, sstack0_p, sstack1_p;
      logic [W-1:0] rd;
      logic         blocked, drain, dma_hit, scsi_hit, line, halt;

      dstat_p   = dstat_ff;
      sist0_p   = sist0_ff;
      sist1_p   = sist1_ff;
      istat_p   = istat_ff;
      dstack_p  = dstack_ff;
      sstack0_p = sstack0_ff;
      sstack1_p = sstack1_ff;
      rd        = '0;
      blocked   = istat_ff[sis_pkg::IST_DIP_POS] | istat_ff[sis_pkg::IST_SIP_POS];

      unique case (sis_pkg::opcode_type'(opcode))
         sis_pkg::OP_POST_DSTAT: begin
            if (blocked) dstack_p = dstack_ff | bits;
            else         dstat_p  = dstat_ff | bits;
         end
         sis_pkg::OP_POST_SIST0: begin
            if (blocked) sstack0_p = sstack0_ff | bits;
            else         sist0_p   = sist0_ff | bits;
         end
         sis_pkg::OP_POST_SIST1: begin
            if (blocked) sstack1_p = sstack1_ff | bits;
            else         sist1_p   = sist1_ff | bits;
         end
         sis_pkg::OP_POST_ISTAT: istat_p = istat_ff | bits;
         sis_pkg::OP_CLEAR_DSTAT: begin
            rd      = dstat_ff;
            dstat_p = sis_pkg::DMA_DONE_BIT;
         end
         sis_pkg::OP_CLEAR_SIST0: begin
            rd      = sist0_ff;
            sist0_p = '0;
         end
         sis_pkg::OP_CLEAR_SIST1: begin
            rd      = sist1_ff;
            sist1_p = '0;
         end
         sis_pkg::OP_CLEAR_ISTAT: istat_p = istat_ff & ~bits;
         default: rd = '0;
      endcase

      // drain the stacks once the SCSI status registers and the DMA status bits other than DMA done are clear
      drain = (sist0_p == '0) && (sist1_p == '0) &&
              ((dstat_p & sis_pkg::DMA_CHECK_MASK) == '0);
      if (drain) begin
         sist0_p   = sist0_p | sstack0_p;
         sist1_p   = sist1_p | sstack1_p;
         dstat_p   = dstat_p | dstack_p;
         sstack0_p = '0;
         sstack1_p = '0;
         dstack_p  = '0;
      end

      dma_hit  = |(dstat_p & sis_pkg::DMA_FATAL_MASK);
      scsi_hit = |(sist0_p & (sis_pkg::SCSI0_FATAL_MASK | cfg.scsi_int_enable0)) ||
                 |(sist1_p & (sis_pkg::SCSI1_FATAL_MASK | cfg.scsi_int_enable1));
      halt     = dma_hit | scsi_hit;
      istat_p[sis_pkg::IST_DIP_POS] = dma_hit;
      istat_p[sis_pkg::IST_SIP_POS] = scsi_hit;

      line = (|(dstat_p & cfg.dma_int_enable & sis_pkg::DMA_FATAL_MASK)) ||
             (scsi_hit && (|(sist0_p & cfg.scsi_int_enable0) ||
                           |(sist1_p & cfg.scsi_int_enable1))) ||
             istat_p[sis_pkg::IST_INTF_POS];
      line = line && !cfg.irq_disable && !host_irq_mask;

      dstat_in   = dstat_p;
      sist0_in   = sist0_p;
      sist1_in   = sist1_p;
      istat_in   = istat_p;
      dstack_in  = dstack_p;
      sstack0_in = sstack0_p;
      sstack1_in = sstack1_p;

      result.irq_line     = line;
      result.halt_request = halt;
      result.istat_value  = istat_p;
      result.read_value   = rd;
      result.bad_opcode   = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dstat_ff   <= sis_pkg::DMA_DONE_BIT;
         sist0_ff   <= '0;
         sist1_ff   <= '0;
         istat_ff   <= '0;
         dstack_ff  <= '0;
         sstack0_ff <= '0;
         sstack1_ff <= '0;
      end else if (fire) begin
         dstat_ff   <= dstat_in;
         sist0_ff   <= sist0_in;
         sist1_ff   <= sist1_in;
         istat_ff   <= istat_in;
         dstack_ff  <= dstack_in;
         sstack0_ff <= sstack0_in;
         sstack1_ff <= sstack1_in;
      end
   end

endmodule

`default_nettype wire

@@ src/scsi_controller_interrupt_stacker.sv @@
// Top level of the SCSI interrupt stacker: request register, update engine,
// response register and configuration port. Depends on sis_pkg, sis_csr and
// sis_engine.
//
// Each request posts bits to one of the DMA status, SCSI status 0/1 or
// interrupt status registers, reads and clears a DMA or SCSI status
// register, or clears the given interrupt status bits; the response carries
// the interrupt line level, halt request, interrupt status and read value
// after that request. The block takes one request per clock while the
// response is not held off. A request sits in the request register and its
// response is held in the response register; the state update is a single
// pass of bitwise logic in the engine, so consecutive requests see each
// other's effects without bubbles. While the response is held off, one request
// waits in each register and the input stalls until the response is taken.
// Write the enable and disable registers only while no request is in flight.
`default_nettype none

module scsi_controller_interrupt_stacker (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [2:0]                           req_opcode,
   input  wire logic [7:0]                           req_bits,
   input  wire logic                                 req_host_irq_mask,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic                                      rsp_irq_line,
   output logic                                      rsp_halt_request,
   output logic      [7:0]                           rsp_istat_value,
   output logic      [7:0]                           rsp_read_value,
   output logic                                      rsp_bad_opcode,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [sis_pkg::CsrAddrWidth-1:0]     csr_paddr,
   input  wire logic [sis_pkg::CsrDataWidth-1:0]     csr_pwdata,
   output logic      [sis_pkg::CsrDataWidth-1:0]     csr_prdata,
   output logic                                      csr_pready
);

   sis_pkg::cfg_type    cfg;
   sis_pkg::result_type result;
   sis_pkg::result_type rsp_ff;

   logic       in_valid_ff, in_valid_in;
   logic       out_valid_ff, out_valid_in;
   logic [2:0] opcode_ff;
   logic [7:0] bits_ff;
   logic       mask_ff;
   logic       advance;
   logic       take;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign take      = req_valid && req_ready;

   assign in_valid_in  = take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   sis_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sis_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .fire          (advance),
      .opcode        (opcode_ff),
      .bits          (bits_ff),
      .host_irq_mask (mask_ff),
      .cfg           (cfg),
      .result        (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         opcode_ff <= req_opcode;
         bits_ff   <= req_bits;
         mask_ff   <= req_host_irq_mask;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_irq_line     = rsp_ff.irq_line;
   assign rsp_halt_request = rsp_ff.halt_request;
   assign rsp_istat_value  = rsp_ff.istat_value;
   assign rsp_read_value   = rsp_ff.read_value;
   assign rsp_bad_opcode   = rsp_ff.bad_opcode;

endmodule

`default_nettype wire
